// ===== rtl/core/sbl_pkg.sv =====
// sbl_pkg: shared types, codes and defaults of the sorted bounded list
// used by sbl_cell and sorted_bounded_list_core, depends on nothing
`default_nettype none

package sbl_pkg;

  localparam int CAPACITY_DEF   = 16;
  localparam int ITEM_WIDTH_DEF = 32;

  localparam int CMD_W   = 2;
  localparam int VALUE_W = 32;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 5;
  localparam int IDX_W   = 1;
  localparam int CFG_W   = 2;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

  localparam logic [STAT_W-1:0] ST_DONE = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
  localparam logic [STAT_W-1:0] ST_NONE = 2'd2;

  localparam logic [IDX_W-1:0] REG_SORT_ORDER     = 1'd0;
  localparam logic [IDX_W-1:0] REG_COMPARE_SIGNED = 1'd1;

  localparam logic [1:0] ORDER_UNSORTED   = 2'd0;
  localparam logic [1:0] ORDER_ASCENDING  = 2'd1;
  localparam logic [1:0] ORDER_DESCENDING = 2'd2;

  typedef struct packed {
    logic do_insert;
    logic do_remove;
    logic sorted;
    logic descending;
    logic cmp_signed;
  } sbl_ctl_t;

  typedef struct packed {
    logic ins;
    logic rem;
  } sbl_chain_t;

endpackage

`default_nettype wire

// ===== rtl/core/sbl_cell.sv =====
// sbl_cell: one list entry with its compare, insert shift and remove shift
// depends on sbl_pkg
`default_nettype none

module sbl_cell #(
  parameter int ITEM_WIDTH = sbl_pkg::ITEM_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire sbl_pkg::sbl_ctl_t      ctl,
  input  wire logic [ITEM_WIDTH-1:0]  item,
  input  wire logic                   occ,
  input  wire logic [ITEM_WIDTH-1:0]  left_data,
  input  wire logic [ITEM_WIDTH-1:0]  right_data,
  input  wire sbl_pkg::sbl_chain_t    chain_in,
  output sbl_pkg::sbl_chain_t         chain_out,
  output logic [ITEM_WIDTH-1:0]       data
);
  import sbl_pkg::*;

  localparam logic [ITEM_WIDTH-1:0] SIGN_BIT = ITEM_WIDTH'(1) << (ITEM_WIDTH - 1);

  logic [ITEM_WIDTH-1:0] data_r, data_nxt;
  logic [ITEM_WIDTH-1:0] key_e, key_i, flip;
  logic                  here, hit, eq;

  always_comb begin
    flip  = ctl.cmp_signed ? SIGN_BIT : '0;
    key_e = data_r ^ flip;
    key_i = item ^ flip;
    here  = ctl.sorted && (ctl.descending ? (key_i >= key_e) : (key_i <= key_e));
    hit   = !occ || here;
    eq    = occ && (data_r == item);
    chain_out.ins = chain_in.ins | hit;
    chain_out.rem = chain_in.rem | eq;
    if (ctl.do_insert && chain_out.ins) begin
      data_nxt = chain_in.ins ? left_data : item;
    end else if (ctl.do_remove && chain_out.rem) begin
      data_nxt = right_data;
    end else begin
      data_nxt = data_r;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

`default_nettype wire

// ===== rtl/core/sorted_bounded_list_core.sv =====
// sorted_bounded_list_core: fixed-capacity list built as a row of sbl_cell
// depends on sbl_pkg and sbl_cell
//
// A command beat is taken whenever start is high; busy never rises, so a
// command can be accepted in every clock cycle. Its result is on the out_
// ports with out_strobe for one cycle, once the command has passed the
// stage_vld_r register and then the out_ registers; the receiver cannot
// stall it. The path is one register stage on the command and one update
// of the cell row, where every entry compares against the item at once
// and shifts toward its neighbor in the same cycle; the insert and remove
// positions ripple along the row as a one-bit chain. Configuration writes
// are always ready and should only be issued while no command is in flight.
`default_nettype none

module sorted_bounded_list_core #(
  parameter int CAPACITY   = sbl_pkg::CAPACITY_DEF,
  parameter int ITEM_WIDTH = sbl_pkg::ITEM_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [sbl_pkg::CMD_W-1:0]     in_command,
  input  wire logic [sbl_pkg::VALUE_W-1:0]   in_item_value,
  output logic                               out_strobe,
  output logic [sbl_pkg::STAT_W-1:0]         out_status,
  output logic [sbl_pkg::VALUE_W-1:0]        out_found_item,
  output logic [sbl_pkg::COUNT_W-1:0]        out_entry_count,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [sbl_pkg::IDX_W-1:0]     cfg_index,
  input  wire logic [sbl_pkg::CFG_W-1:0]     cfg_data
);
  import sbl_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic                  stage_vld_r;
  logic [CMD_W-1:0]      cmd_r;
  logic [ITEM_WIDTH-1:0] item_r, item_in;
  logic [1:0]            sort_order_r;
  logic                  cmp_signed_r;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic                  full;
  sbl_ctl_t              ctl;
  sbl_chain_t            chain [CAPACITY+1];
  logic [ITEM_WIDTH-1:0] cell_data [CAPACITY];

  logic                  out_strobe_r;
  logic [STAT_W-1:0]     out_status_r, status_nxt;
  logic [ITEM_WIDTH-1:0] out_found_r, found_nxt;
  logic [CNT_W-1:0]      out_count_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  generate
    if (ITEM_WIDTH <= VALUE_W) begin : g_in_narrow
      assign item_in        = in_item_value[ITEM_WIDTH-1:0];
      assign out_found_item = VALUE_W'(out_found_r);
    end else begin : g_in_wide
      assign item_in        = ITEM_WIDTH'(in_item_value);
      assign out_found_item = out_found_r[VALUE_W-1:0];
    end
    if (CNT_W <= COUNT_W) begin : g_cnt_narrow
      assign out_entry_count = COUNT_W'(out_count_r);
    end else begin : g_cnt_wide
      assign out_entry_count = out_count_r[COUNT_W-1:0];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sort_order_r <= ORDER_UNSORTED;
      cmp_signed_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SORT_ORDER:     sort_order_r <= cfg_data;
        REG_COMPARE_SIGNED: cmp_signed_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_vld_r <= 1'b0;
    end else begin
      stage_vld_r <= start && !busy;
    end
    cmd_r  <= in_command;
    item_r <= item_in;
  end

  assign full = (count_r == CNT_W'(CAPACITY));

  always_comb begin
    ctl.do_insert  = stage_vld_r && (cmd_r == CMD_INSERT) && !full;
    ctl.do_remove  = stage_vld_r && (cmd_r == CMD_REMOVE);
    ctl.sorted     = (sort_order_r == ORDER_ASCENDING) ||
                     (sort_order_r == ORDER_DESCENDING);
    ctl.descending = (sort_order_r == ORDER_DESCENDING);
    ctl.cmp_signed = cmp_signed_r;
  end

  assign chain[0] = '0;

  generate
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [ITEM_WIDTH-1:0] left_d, right_d;
      if (i == 0) begin : g_head
        assign left_d = item_r;
      end else begin : g_left
        assign left_d = cell_data[i-1];
      end
      if (i == CAPACITY - 1) begin : g_tail
        assign right_d = cell_data[i];
      end else begin : g_right
        assign right_d = cell_data[i+1];
      end
      sbl_cell #(
        .ITEM_WIDTH(ITEM_WIDTH)
      ) u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .item       (item_r),
        .occ        (CNT_W'(i) < count_r),
        .left_data  (left_d),
        .right_data (right_d),
        .chain_in   (chain[i]),
        .chain_out  (chain[i+1]),
        .data       (cell_data[i])
      );
    end
  endgenerate

  always_comb begin
    count_nxt  = count_r;
    status_nxt = ST_DONE;
    found_nxt  = '0;
    case (cmd_r)
      CMD_INSERT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
      CMD_REMOVE: begin
        if (chain[CAPACITY].rem) begin
          count_nxt = count_r - CNT_W'(1);
        end else begin
          status_nxt = ST_NONE;
        end
      end
      CMD_SEARCH: begin
        if (chain[CAPACITY].rem) begin
          found_nxt = item_r;
        end else begin
          status_nxt = ST_NONE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= stage_vld_r;
      if (stage_vld_r) begin
        count_r <= count_nxt;
      end
    end
    if (stage_vld_r) begin
      out_status_r <= status_nxt;
      out_found_r  <= found_nxt;
      out_count_r  <= count_nxt;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_status = out_status_r;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_beat_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##1 out_strobe)
    else $error("result beat missing two cycles after command");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status == ST_FULL) |-> out_count_r == CNT_W'(CAPACITY))
    else $error("full reported on a list that is not full");

  a_found_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status != ST_DONE) |-> out_found_r == '0)
    else $error("found item on a failed command");
`endif

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// tb: self-checking bench for sorted_bounded_list_core, with directed table and random phases
// depends on sbl_pkg and the core; results are checked against an in-bench list predictor
`timescale 1ns / 1ps

module tb;
  import sbl_pkg::*;

  localparam int CAP          = CAPACITY_DEF;
  localparam int DRAIN_CYCLES = 4;
  localparam int STALL_LIMIT  = 1000;
  localparam int PHASE_ITEMS  = 112;
  localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;
  localparam logic [1:0] ORDER_SPARE = 2'd3;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [VALUE_W-1:0] found;
    logic [COUNT_W-1:0] count;
  } list_result_t;

  typedef struct packed {
    logic               is_cfg;
    logic [IDX_W-1:0]   idx;
    logic [CFG_W-1:0]   data;
    logic [CMD_W-1:0]   cmd;
    logic [VALUE_W-1:0] val;
    logic               typed;
    list_result_t       exp;
  } step_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [CMD_W-1:0]   in_command = '0;
  logic [VALUE_W-1:0] in_item_value = '0;
  logic               out_strobe;
  logic [STAT_W-1:0]  out_status;
  logic [VALUE_W-1:0] out_found_item;
  logic [COUNT_W-1:0] out_entry_count;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [IDX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]   cfg_data = '0;

  logic               row_typed = 1'b0;
  list_result_t       row_exp = '0;

  logic [VALUE_W-1:0] list_mem [0:CAP-1];
  int                 list_len = 0;
  logic [1:0]         cur_order = ORDER_UNSORTED;
  logic               cur_signed = 1'b0;

  list_result_t       pending_results [$];
  step_row_t          plan [$];
  logic [VALUE_W-1:0] corner_vals [0:5] = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF,
                                            32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001};

  int err_count = 0;
  int cmds_taken = 0;
  int full_seen = 0;
  int miss_seen = 0;
  int reg_writes = 0;
  int stall_cycles = 0;
  int idle_pct = 0;

  sorted_bounded_list_core DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_command      (in_command),
    .in_item_value   (in_item_value),
    .out_strobe      (out_strobe),
    .out_status      (out_status),
    .out_found_item  (out_found_item),
    .out_entry_count (out_entry_count),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #2 clk = ~clk;

  function automatic logic [VALUE_W-1:0] order_key(input logic [VALUE_W-1:0] v);
    return cur_signed ? {~v[VALUE_W-1], v[VALUE_W-2:0]} : v;
  endfunction

  function automatic list_result_t apply_command(input logic [CMD_W-1:0] cmd,
                                                 input logic [VALUE_W-1:0] val);
    list_result_t r;
    int i;
    int at;
    int hit;
    logic placed;
    logic ahead;
    logic [VALUE_W-1:0] key_new;
    r.status = ST_DONE;
    r.found = '0;
    hit = -1;
    for (i = 0; i < list_len; i++)
      if (hit < 0 && list_mem[i] == val) hit = i;
    case (cmd)
      CMD_INSERT: begin
        if (list_len >= CAP) begin
          r.status = ST_FULL;
        end else begin
          at = list_len;
          placed = 1'b0;
          if (cur_order == ORDER_ASCENDING || cur_order == ORDER_DESCENDING) begin
            key_new = order_key(val);
            for (i = 0; i < list_len; i++) begin
              ahead = (cur_order == ORDER_ASCENDING) ? (key_new <= order_key(list_mem[i]))
                                                      : (key_new >= order_key(list_mem[i]));
              if (ahead && !placed) begin
                at = i;
                placed = 1'b1;
              end
            end
          end
          for (i = list_len; i > at; i--) list_mem[i] = list_mem[i-1];
          list_mem[at] = val;
          list_len++;
        end
      end
      CMD_REMOVE: begin
        if (hit < 0) begin
          r.status = ST_NONE;
        end else begin
          for (i = hit; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
          list_len--;
        end
      end
      CMD_SEARCH: begin
        if (hit < 0) r.status = ST_NONE;
        else r.found = list_mem[hit];
      end
      default: ;
    endcase
    r.count = list_len[COUNT_W-1:0];
    return r;
  endfunction

  function automatic step_row_t cmd_row(input logic [CMD_W-1:0] cmd,
                                        input logic [VALUE_W-1:0] val);
    step_row_t s;
    s = '0;
    s.cmd = cmd;
    s.val = val;
    return s;
  endfunction

  function automatic step_row_t typed_row(input logic [CMD_W-1:0] cmd,
                                          input logic [VALUE_W-1:0] val,
                                          input logic [STAT_W-1:0] st,
                                          input logic [VALUE_W-1:0] found,
                                          input logic [COUNT_W-1:0] cnt);
    step_row_t s;
    s = cmd_row(cmd, val);
    s.typed = 1'b1;
    s.exp.status = st;
    s.exp.found = found;
    s.exp.count = cnt;
    return s;
  endfunction

  function automatic step_row_t cfg_row(input logic [IDX_W-1:0] idx,
                                        input logic [CFG_W-1:0] data);
    step_row_t s;
    s = '0;
    s.is_cfg = 1'b1;
    s.idx = idx;
    s.data = data;
    return s;
  endfunction

  task automatic issue(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] val,
                       input logic typed, input list_result_t exp);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_command <= cmd;
    in_item_value <= val;
    row_typed <= typed;
    row_exp <= exp;
    do @(posedge clk); while (busy);
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_SORT_ORDER) cur_order = data;
    else cur_signed = data[0];
    reg_writes++;
    @(posedge clk);
  endtask

  // check results first, then take the command beat of this edge into the predictor
  always @(posedge clk) begin : monitor
    list_result_t got;
    list_result_t want;
    logic active;
    active = 1'b0;
    if (rst_n) begin
      if (out_strobe) begin
        active = 1'b1;
        got.status = out_status;
        got.found = out_found_item;
        got.count = out_entry_count;
        if (pending_results.size() == 0) begin
          err_count++;
          $display("%0t: unexpected result, expected none, got status %0d item %h count %0d",
                   $time, got.status, got.found, got.count);
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status) begin
            err_count++;
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, want.status, got.status);
          end
          if (got.found !== want.found) begin
            err_count++;
            $display("%0t: found_item mismatch, expected %h, got %h",
                     $time, want.found, got.found);
          end
          if (got.count !== want.count) begin
            err_count++;
            $display("%0t: entry_count mismatch, expected %0d, got %0d",
                     $time, want.count, got.count);
          end
        end
      end
      if (start && !busy) begin
        active = 1'b1;
        want = apply_command(in_command, in_item_value);
        if (row_typed) want = row_exp;
        if (want.status == ST_FULL) full_seen++;
        if (want.status == ST_NONE) miss_seen++;
        cmds_taken++;
        pending_results.push_back(want);
      end
      if (cfg_valid && cfg_ready) active = 1'b1;
      stall_cycles = active ? 0 : stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [1:0] order_plan [0:7];
    logic [CFG_W-1:0] sign_plan [0:7];
    int idle_plan [0:3];
    int ph;
    int n;
    int r;
    int p;
    int ins_w;
    logic [CMD_W-1:0] cmd;
    logic [VALUE_W-1:0] val;
    step_row_t s;

    order_plan = '{ORDER_UNSORTED, ORDER_ASCENDING, ORDER_DESCENDING, ORDER_SPARE,
                   ORDER_ASCENDING, ORDER_DESCENDING, ORDER_UNSORTED, ORDER_ASCENDING};
    sign_plan = '{2'd0, 2'd1, 2'd3, 2'd0, 2'd2, 2'd1, 2'd1, 2'd0};
    idle_plan = '{0, 77, 0, 27};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty list after reset, then unsorted append and removal
    plan.push_back(typed_row(CMD_SEARCH, 32'h0, ST_NONE, 32'h0, 5'd0));
    plan.push_back(typed_row(CMD_REMOVE, 32'h5, ST_NONE, 32'h0, 5'd0));
    plan.push_back(typed_row(CMD_NOP, 32'hFFFF_FFFF, ST_DONE, 32'h0, 5'd0));
    plan.push_back(typed_row(CMD_INSERT, 32'hFFFF_FFFF, ST_DONE, 32'h0, 5'd1));
    plan.push_back(typed_row(CMD_INSERT, 32'h0, ST_DONE, 32'h0, 5'd2));
    plan.push_back(typed_row(CMD_SEARCH, 32'hFFFF_FFFF, ST_DONE, 32'hFFFF_FFFF, 5'd2));
    plan.push_back(typed_row(CMD_REMOVE, 32'h0, ST_DONE, 32'h0, 5'd1));
    plan.push_back(typed_row(CMD_REMOVE, 32'hFFFF_FFFF, ST_DONE, 32'h0, 5'd0));
    // signed ascending with duplicates
    plan.push_back(cfg_row(REG_SORT_ORDER, ORDER_ASCENDING));
    plan.push_back(cfg_row(REG_COMPARE_SIGNED, 2'd1));
    plan.push_back(cmd_row(CMD_INSERT, 32'h8000_0000));
    plan.push_back(cmd_row(CMD_INSERT, 32'h7FFF_FFFF));
    plan.push_back(cmd_row(CMD_INSERT, 32'h0));
    plan.push_back(cmd_row(CMD_INSERT, 32'h0));
    plan.push_back(cmd_row(CMD_INSERT, 32'hFFFF_FFFF));
    // order flipped with items stored
    plan.push_back(cfg_row(REG_SORT_ORDER, ORDER_DESCENDING));
    plan.push_back(cmd_row(CMD_INSERT, 32'h1));
    plan.push_back(cmd_row(CMD_INSERT, 32'h8000_0000));
    plan.push_back(cfg_row(REG_COMPARE_SIGNED, 2'd2));
    plan.push_back(cmd_row(CMD_INSERT, 32'h8000_0001));
    // spare order code appends
    plan.push_back(cfg_row(REG_SORT_ORDER, ORDER_SPARE));
    plan.push_back(cmd_row(CMD_INSERT, 32'h1234_5678));
    plan.push_back(cmd_row(CMD_INSERT, 32'hA5A5_A5A5));
    plan.push_back(cmd_row(CMD_INSERT, 32'h5A5A_5A5A));
    plan.push_back(cmd_row(CMD_INSERT, 32'h1));
    plan.push_back(cmd_row(CMD_INSERT, 32'h2));
    plan.push_back(cmd_row(CMD_INSERT, 32'h3));
    plan.push_back(cmd_row(CMD_INSERT, 32'h4));
    plan.push_back(cmd_row(CMD_INSERT, 32'h5));
    // list full
    plan.push_back(typed_row(CMD_INSERT, 32'h0, ST_FULL, 32'h0, 5'd16));
    plan.push_back(cmd_row(CMD_SEARCH, 32'h1234_5678));

    idle_pct = 27;
    foreach (plan[i]) begin
      s = plan[i];
      if (s.is_cfg) begin
        settle();
        write_reg(s.idx, s.data);
      end else begin
        issue(s.cmd, s.val, s.typed, s.exp);
      end
    end
    settle();

    for (ph = 0; ph < 8; ph++) begin
      write_reg(REG_SORT_ORDER, order_plan[ph]);
      write_reg(REG_COMPARE_SIGNED, sign_plan[ph]);
      idle_pct = idle_plan[ph % 4];
      ins_w = $urandom_range(65, 25);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(99);
        if (r < 5) cmd = CMD_NOP;
        else if (r < 5 + ins_w) cmd = CMD_INSERT;
        else if (r < 5 + ins_w + (95 - ins_w) / 2) cmd = CMD_REMOVE;
        else cmd = CMD_SEARCH;
        p = $urandom_range(9);
        if (p < 4 && list_len > 0) val = list_mem[$urandom_range(list_len - 1)];
        else if (p < 6) val = corner_vals[$urandom_range(5)];
        else if (p < 7) val = $urandom_range(7);
        else val = $urandom;
        issue(cmd, val, 1'b0, '0);
      end
      settle();
    end

    repeat (2 * DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d commands across %0d register writes", cmds_taken, reg_writes);
    $display("including %0d inserts into a full list and %0d failed lookups",
             full_seen, miss_seen);
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
